@@ hw/rtl/rhpm_pkg.sv @@
`default_nettype none
package rhpm_pkg;

  localparam int unsigned HashW   = 23;
  localparam int unsigned PatLenW = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] RegPatternLength = 2'd0;
  localparam logic [1:0] RegTargetHash    = 2'd1;
  localparam logic [1:0] RegTopPower      = 2'd2;

  localparam logic [PatLenW-1:0] PatternLengthRst = PatLenW'(1);
  localparam logic [HashW-1:0]   TargetHashRst    = '0;
  localparam logic [HashW-1:0]   TopPowerRst      = HashW'(1);

  typedef struct packed {
    logic [PatLenW-1:0] pattern_length;
    logic [HashW-1:0]   target_hash;
    logic [HashW-1:0]   top_power;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

endpackage
`default_nettype wire

@@ hw/rtl/rhpm_ram.sv @@
`default_nettype none
module rhpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire  [Width-1:0]                          wdata_i,
  input  wire                                       re_i,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rhpm_cfg.sv @@
`default_nettype none
module rhpm_cfg (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [rhpm_pkg::ApbAddrW-1:0]    paddr,
  input  wire  [rhpm_pkg::ApbDataW-1:0]    pwdata,
  output logic [rhpm_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output rhpm_pkg::cfg_t                   cfg_o
);
  import rhpm_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= PatternLengthRst;
      cfg_q.target_hash    <= TargetHashRst;
      cfg_q.top_power      <= TopPowerRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegPatternLength: cfg_q.pattern_length <= pwdata[PatLenW-1:0];
        RegTargetHash:    cfg_q.target_hash    <= pwdata[HashW-1:0];
        RegTopPower:      cfg_q.top_power      <= pwdata[HashW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPatternLength: prdata = ApbDataW'(cfg_q.pattern_length);
      RegTargetHash:    prdata = ApbDataW'(cfg_q.target_hash);
      RegTopPower:      prdata = ApbDataW'(cfg_q.top_power);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/rhpm_core.sv @@
`default_nettype none
module rhpm_core #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rhpm_pkg::cfg_t               cfg_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [rhpm_pkg::ByteW-1:0]   in_byte_i,
  input  wire                          in_restart_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         out_match_o,
  output logic                         out_full_o
);
  import rhpm_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SlotW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CmpW  = (LenW > PatLenW) ? LenW : PatLenW;
  localparam int unsigned AW    = CmpW + 1;

  state_e state_q, state_d;

  logic [HashW-1:0] hash_q;
  logic [LenW-1:0]  fill_q;
  logic [SlotW-1:0] slot_q;
  logic [LenW-1:0]  len_q;
  logic             rm_q;
  logic [ByteW-1:0] byte_q;
  logic [HashW-1:0] prod_q;
  logic             out_valid_q, out_match_q, out_full_q;

  logic             accept;
  logic             upd_done;
  logic [CmpW-1:0]  pl_ext;
  logic [LenW-1:0]  eff_len;
  logic [LenW-1:0]  fill_eff;
  logic [SlotW-1:0] slot_eff;
  logic [AW-1:0]    slot_ext, len_ext, old_ext;
  logic [SlotW-1:0] old_slot;
  logic [ByteW-1:0] ram_rdata;
  logic [HashW-1:0] prod_full;
  logic [HashW-1:0] diff, hash_new;
  logic [LenW-1:0]  fill_new;
  logic [SlotW-1:0] slot_new;
  logic             full_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign upd_done   = (state_q == ST_UPD) & (~out_valid_q | out_ready_i);

  // window length clamped to 1..MAX_PATTERN
  always_comb begin
    pl_ext = CmpW'(cfg_i.pattern_length);
    if (cfg_i.pattern_length == '0) begin
      eff_len = LenW'(1);
    end else if (pl_ext > CmpW'(MAX_PATTERN)) begin
      eff_len = LenW'(MAX_PATTERN);
    end else begin
      eff_len = pl_ext[LenW-1:0];
    end
  end

  assign fill_eff = in_restart_i ? '0 : fill_q;
  assign slot_eff = in_restart_i ? '0 : slot_q;
  assign slot_ext = AW'(slot_eff);
  assign len_ext  = AW'(eff_len);

  always_comb begin
    if (slot_ext >= len_ext) begin
      old_ext = slot_ext - len_ext;
    end else begin
      old_ext = slot_ext + AW'(MAX_PATTERN) - len_ext;
    end
  end
  assign old_slot = old_ext[SlotW-1:0];

  // previous write lands before the next accept, so no read/write overlap
  rhpm_ram #(
    .Width (ByteW),
    .Depth (MAX_PATTERN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (upd_done),
    .waddr_i (slot_q),
    .wdata_i (byte_q),
    .re_i    (accept),
    .raddr_i (old_slot),
    .rdata_o (ram_rdata)
  );

  // only the low hash bits of the product matter
  assign prod_full = {{(HashW-ByteW){ram_rdata[ByteW-1]}}, ram_rdata} * cfg_i.top_power;

  assign diff     = hash_q - prod_q;
  // x*129 = (x << 7) + x
  assign hash_new = {diff[HashW-8:0], 7'b0} + diff
                    + {{(HashW-ByteW){byte_q[ByteW-1]}}, byte_q};
  assign fill_new = (fill_q < LenW'(MAX_PATTERN)) ? fill_q + LenW'(1) : fill_q;
  assign slot_new = (slot_q == SlotW'(MAX_PATTERN - 1)) ? '0 : slot_q + SlotW'(1);
  assign full_new = (fill_new >= len_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept)   state_d = ST_MUL;
      ST_MUL:                state_d = ST_UPD;
      ST_UPD:  if (upd_done) state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        hash_q <= in_restart_i ? '0 : hash_q;
        fill_q <= fill_eff;
        slot_q <= slot_eff;
      end else if (upd_done) begin
        hash_q <= hash_new;
        fill_q <= fill_new;
        slot_q <= slot_new;
      end
      if (upd_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      len_q  <= eff_len;
      rm_q   <= (fill_eff >= eff_len);
    end
    if (state_q == ST_MUL) begin
      prod_q <= rm_q ? prod_full : '0;
    end
    if (upd_done) begin
      out_full_q  <= full_new;
      out_match_q <= full_new & (hash_new == cfg_i.target_hash);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_match_o = out_match_q;
  assign out_full_o  = out_full_q;

endmodule
`default_nettype wire

@@ hw/rtl/rolling_hash_pattern_match_top.sv @@
// After an input beat is accepted, its result beat is valid once the multiply and update
// states have run, plus master stalls. A new byte is taken only after the window RAM read,
// the oldest-byte multiply and the hash update/write-back are done in turn for the last byte.
// A result held on the master side stalls the next byte at its update step.
// Reset (rst_ni low, async): hash, fill count and write slot clear, registers take
// pattern_length 1, target_hash 0, top_power 1; window RAM content is not cleared.
`default_nettype none
module rolling_hash_pattern_match_top #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [7:0]                     s_axis_tdata,  // [7:0] byte_value
  input  wire                            s_axis_tuser,  // [0] first_of_block
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [0] match, [1] window_full
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [rhpm_pkg::ApbAddrW-1:0]  paddr,
  input  wire  [rhpm_pkg::ApbDataW-1:0]  pwdata,
  output logic [rhpm_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import rhpm_pkg::*;

  cfg_t cfg;
  logic out_match, out_full;

  rhpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rhpm_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_match_o  (out_match),
    .out_full_o   (out_full)
  );

  assign m_axis_tdata = {6'b0, out_full, out_match};

endmodule
`default_nettype wire
